>>> rtl/lpr_pkg.sv
// Shared constants, types and controller states for the LRU page replacement block.
`default_nettype none
package lpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CFG_W      = 5;
  localparam int TOTAL_W    = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_FRAMES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } lpr_state_e;

  typedef struct packed {
    logic load;
    logic decide;
    logic commit;
  } lpr_cmd_t;

endpackage
`default_nettype wire

>>> rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block.
// A reference beat is taken on page_i at a rising edge where start is high
// and busy is low. The block then looks the page up in the active frames,
// decides between hit, fill of the lowest empty frame and eviction of the
// least recently used frame, and commits the new table and ranks.
// Each reference goes through capture, lookup and commit in turn. The result
// beat is registered at the commit and shown on fault_o, frame_index_o,
// victim_page_o and fault_total_o, marked by done_o for exactly one cycle.
// A new reference is accepted only once the previous one has committed, in
// the same cycle that the previous result beat is shown. The lookup compares
// all frames in parallel and finds the oldest active frame by a full rank
// comparison.
// The receiver cannot stall, so every result beat must be taken when shown.
// The user must write the frame count through cfg_we_i and cfg_wdata_i only
// while idle, which the block does not enforce; 0 acts as 1, above 16 as 16.
// Reset empties all frames, sets the rank of each frame to its index, clears
// the fault total and sets the frame count to 16.
// A reference to page 0 changes nothing and reports a hit on frame 0.
`default_nettype none
module lru_page_replacement
  import lpr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      done_o,
  output logic                      fault_o,
  output logic [FRAME_W-1:0]        frame_index_o,
  output logic [PAGE_BITS-1:0]      victim_page_o,
  output logic [TOTAL_W-1:0]        fault_total_o
);

  lpr_cmd_t cmd;

  lpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  lpr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .page_i        (page_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fault_o       (fault_o),
    .frame_index_o (frame_index_o),
    .victim_page_o (victim_page_o),
    .fault_total_o (fault_total_o)
  );

endmodule
`default_nettype wire

>>> rtl/lpr_ctrl.sv
// Controller state machine that sequences capture, lookup and commit of one reference.
`default_nettype none
module lpr_ctrl
  import lpr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  output logic          done_o,
  output lpr_cmd_t      cmd_o
);

  lpr_state_e state_q, state_d;
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.commit;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

>>> rtl/lpr_datapath.sv
// Frame table, recency ranks, fault counter and result registers.
`default_nettype none
module lpr_datapath
  import lpr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lpr_cmd_t             cmd_i,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      fault_o,
  output logic [FRAME_W-1:0]        frame_index_o,
  output logic [PAGE_BITS-1:0]      victim_page_o,
  output logic [TOTAL_W-1:0]        fault_total_o
);

  logic [PAGE_BITS-1:0]  frame_q [MAX_FRAMES];
  logic [FRAME_W-1:0]    rank_q  [MAX_FRAMES];
  logic [TOTAL_W-1:0]    count_q, count_d;
  logic [CFG_W-1:0]      cfg_q;
  logic [PAGE_BITS-1:0]  page_q;

  logic                  dec_use_q, dec_fault_q;
  logic [FRAME_W-1:0]    dec_idx_q;
  logic [PAGE_BITS-1:0]  dec_victim_q;

  logic                  out_fault_q;
  logic [FRAME_W-1:0]    out_idx_q;
  logic [PAGE_BITS-1:0]  out_victim_q;
  logic [TOTAL_W-1:0]    out_total_q;

  logic [CFG_W-1:0]      n_act;
  logic [MAX_FRAMES-1:0] act, hit, empty, oldest;
  logic [FRAME_W-1:0]    hit_idx, empty_idx, old_idx, sel_idx;
  logic                  use_c, fault_c;
  logic [PAGE_BITS-1:0]  victim_c;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg_q > CFG_W'(MAX_FRAMES)) begin
      n_act = CFG_W'(MAX_FRAMES);
    end else begin
      n_act = cfg_q;
    end
  end

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    old_idx   = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act[i]    = CFG_W'(i) < n_act;
      hit[i]    = act[i] && (frame_q[i] == page_q);
      empty[i]  = act[i] && (frame_q[i] == '0);
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      oldest[i] = act[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (act[j] && (rank_q[j] > rank_q[i])) begin
          oldest[i] = 1'b0;
        end
      end
    end
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = FRAME_W'(i);
      end
      if (empty[i]) begin
        empty_idx = FRAME_W'(i);
      end
      if (oldest[i]) begin
        old_idx = FRAME_W'(i);
      end
    end
  end

  always_comb begin
    use_c    = page_q != '0;
    fault_c  = 1'b0;
    sel_idx  = '0;
    victim_c = '0;
    if (use_c) begin
      if (|hit) begin
        sel_idx = hit_idx;
      end else if (|empty) begin
        fault_c = 1'b1;
        sel_idx = empty_idx;
      end else begin
        fault_c  = 1'b1;
        sel_idx  = old_idx;
        victim_c = frame_q[old_idx];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (dec_use_q && dec_fault_q && (count_q != '1)) begin
      count_d = count_q + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CFG_RESET;
      count_q <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_q[i] <= '0;
        rank_q[i]  <= FRAME_W'(i);
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        if (dec_use_q) begin
          if (dec_fault_q) begin
            frame_q[dec_idx_q] <= page_q;
          end
          for (int i = 0; i < MAX_FRAMES; i++) begin
            if (FRAME_W'(i) == dec_idx_q) begin
              rank_q[i] <= '0;
            end else if (rank_q[i] < rank_q[dec_idx_q]) begin
              rank_q[i] <= rank_q[i] + FRAME_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_i;
    end
    if (cmd_i.decide) begin
      dec_use_q    <= use_c;
      dec_fault_q  <= fault_c;
      dec_idx_q    <= sel_idx;
      dec_victim_q <= victim_c;
    end
    if (cmd_i.commit) begin
      out_fault_q  <= dec_fault_q;
      out_idx_q    <= dec_idx_q;
      out_victim_q <= dec_victim_q;
      out_total_q  <= count_d;
    end
  end

  assign fault_o       = out_fault_q;
  assign frame_index_o = out_idx_q;
  assign victim_page_o = out_victim_q;
  assign fault_total_o = out_total_q;

endmodule
`default_nettype wire

>>> rtl/lpr_checker.sv
// Port-level checker for the LRU page replacement block and its bind.
`default_nettype none
module lpr_checker
  import lpr_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done_o,
  input wire logic                 fault_o,
  input wire logic [PAGE_BITS-1:0] victim_page_o,
  input wire logic [TOTAL_W-1:0]   fault_total_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result beat missing three cycles after acceptance");

  a_hit_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !fault_o) |-> (victim_page_o == '0))
    else $error("victim page reported on a hit");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fault_o) |-> (fault_total_o != '0))
    else $error("fault reported with zero fault total");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .fault_o       (fault_o),
  .victim_page_o (victim_page_o),
  .fault_total_o (fault_total_o)
);
`default_nettype wire

>>> test/lru_page_replacement_checker.sv
// Checker for the LRU page replacement block: predicts each lookup and compares result beats.
`timescale 1ns / 1ps
module lru_page_replacement_checker
  import lpr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 done_o,
  input  wire logic                 fault_o,
  input  wire logic [FRAME_W-1:0]   frame_index_o,
  input  wire logic [PAGE_BITS-1:0] victim_page_o,
  input  wire logic [TOTAL_W-1:0]   fault_total_o,
  output int                        fail_count,
  output int                        pending,
  output int                        hit_count,
  output int                        fill_count,
  output int                        evict_count,
  output int                        zero_count,
  output int                        setting_count
);

  typedef struct packed {
    logic                 fault;
    logic [FRAME_W-1:0]   frame;
    logic [PAGE_BITS-1:0] victim;
    logic [TOTAL_W-1:0]   total;
  } lookup_t;

  logic [PAGE_BITS-1:0] frame_pg [MAX_FRAMES];
  logic [FRAME_W-1:0]   frame_rank [MAX_FRAMES];
  logic [TOTAL_W-1:0]   fault_tally;
  logic [CFG_W-1:0]     frames_cfg;
  lookup_t              expected_lookups [$];

  function automatic lookup_t lookup_page(input logic [PAGE_BITS-1:0] pg);
    lookup_t            r;
    int                 n;
    int                 f;
    bit                 found;
    logic [FRAME_W-1:0] top_rank;
    logic [FRAME_W-1:0] used_rank;
    r = '0;
    r.total = fault_tally;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    if (pg == '0) return r;
    f = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_pg[i] == pg) begin
        f = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.fault = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!found && frame_pg[i] == '0) begin
          f = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        top_rank = frame_rank[0];
        f = 0;
        for (int i = 1; i < n; i++) begin
          if (frame_rank[i] > top_rank) begin
            top_rank = frame_rank[i];
            f = i;
          end
        end
        r.victim = frame_pg[f];
      end
      frame_pg[f] = pg;
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
    end
    used_rank = frame_rank[f];
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (frame_rank[i] < used_rank) frame_rank[i] = frame_rank[i] + 1'b1;
    end
    frame_rank[f] = '0;
    r.frame = FRAME_W'(f);
    r.total = fault_tally;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_pg[i] = '0;
        frame_rank[i] = FRAME_W'(i);
      end
      fault_tally = '0;
      frames_cfg = CFG_RESET;
      expected_lookups.delete();
      pending <= 0;
      fail_count = 0;
      hit_count = 0;
      fill_count = 0;
      evict_count = 0;
      zero_count = 0;
      setting_count = 0;
    end else begin
      if (done_o === 1'b1) begin
        if (expected_lookups.size() == 0) begin
          $error("result beat with no reference outstanding");
          fail_count++;
        end else begin
          want = expected_lookups.pop_front();
          if (fault_o !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, fault_o);
            fail_count++;
          end
          if (frame_index_o !== want.frame) begin
            $error("frame_index: expected %0d, got %0d", want.frame, frame_index_o);
            fail_count++;
          end
          if (victim_page_o !== want.victim) begin
            $error("victim_page: expected %0h, got %0h", want.victim, victim_page_o);
            fail_count++;
          end
          if (fault_total_o !== want.total) begin
            $error("fault_total: expected %0d, got %0d", want.total, fault_total_o);
            fail_count++;
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        frames_cfg = cfg_wdata_i;
        setting_count++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = lookup_page(page_i);
        expected_lookups.push_back(want);
        if (page_i == '0) zero_count++;
        else if (!want.fault) hit_count++;
        else if (want.victim == '0) fill_count++;
        else evict_count++;
      end
      pending <= expected_lookups.size();
    end
  end

endmodule

>>> test/tb_lru_page_replacement.sv
// Testbench top for the LRU page replacement block: reset, stimulus, timeout and verdict.
`timescale 1ns / 1ps
module tb_lru_page_replacement
  import lpr_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BEATS = 160;

  bit                   clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [PAGE_BITS-1:0] page_i;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 done_o;
  logic                 fault_o;
  logic [FRAME_W-1:0]   frame_index_o;
  logic [PAGE_BITS-1:0] victim_page_o;
  logic [TOTAL_W-1:0]   fault_total_o;

  int fail_count;
  int pending;
  int hit_count;
  int fill_count;
  int evict_count;
  int zero_count;
  int setting_count;
  int cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lru_page_replacement dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .page_i       (page_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .fault_o      (fault_o),
    .frame_index_o(frame_index_o),
    .victim_page_o(victim_page_o),
    .fault_total_o(fault_total_o)
  );

  lru_page_replacement_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .page_i       (page_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .fault_o      (fault_o),
    .frame_index_o(frame_index_o),
    .victim_page_o(victim_page_o),
    .fault_total_o(fault_total_o),
    .fail_count   (fail_count),
    .pending      (pending),
    .hit_count    (hit_count),
    .fill_count   (fill_count),
    .evict_count  (evict_count),
    .zero_count   (zero_count),
    .setting_count(setting_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d beats outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_ref(input logic [PAGE_BITS-1:0] pg);
    start <= 1'b1;
    page_i <= pg;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] value, input int idle_pct);
    int                   active;
    int                   roll;
    logic [PAGE_BITS-1:0] pg;
    write_frames(value);
    active = int'(value);
    if (active < 1) active = 1;
    if (active > MAX_FRAMES) active = MAX_FRAMES;
    for (int k = 0; k < PHASE_BEATS; k++) begin
      roll = $urandom_range(99);
      if (roll < 4) pg = '0;
      else if (roll < 14) pg = PAGE_BITS'($urandom_range(65535, 1));
      else if (roll < 18) pg = 16'hFFFF - PAGE_BITS'($urandom_range(7));
      else pg = PAGE_BITS'($urandom_range(active + 4, 1));
      send_ref(pg);
      if ($urandom_range(99) < idle_pct) pause($urandom_range(4, 1));
      if ($urandom_range(199) == 0) drain();
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [10] = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd16,
                                        5'd17, 5'd3, 5'd2, 5'd12, 5'd16};
    int               idle_plan [4] = '{0, 50, 0, 22};
    rst_ni <= 1'b0;
    start <= 1'b0;
    page_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_frames(5'd4);
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    send_ref(16'h0001);
    send_ref(16'hAAAA);
    send_ref(16'h5555);
    send_ref(16'h0001);
    send_ref(16'h8000);
    send_ref(16'h5555);
    send_ref(16'h0002);
    send_ref(16'h0000);
    write_frames(5'd1);
    send_ref(16'h5555);
    send_ref(16'h0009);
    write_frames(5'd31);
    send_ref(16'h5555);
    send_ref(16'h0003);
    send_ref(16'h0002);
    send_ref(16'hFFFF);

    for (int p = 0; p < 10; p++) run_phase(settings[p], idle_plan[p % 4]);

    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d hits, %0d fills, %0d evictions and %0d zero pages",
             hit_count, fill_count, evict_count, zero_count);
    $display("over %0d frame count settings in %0d cycles", setting_count, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lpr_pkg.sv
rtl/lpr_ctrl.sv
rtl/lpr_datapath.sv
rtl/lru_page_replacement.sv
rtl/lpr_checker.sv
test/lru_page_replacement_checker.sv
test/tb_lru_page_replacement.sv
